// ----- rtl/bap_pkg.sv -----
package bap_pkg;

	localparam int CHAN_W     = 16;
	localparam int LANES      = 4;
	localparam int PIX_W      = CHAN_W * LANES;
	localparam int SUM_W      = 32;
	localparam int DVD_W      = SUM_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int BSIZE_W    = 9;
	localparam int ISIZE_W    = 13;

	localparam logic [BSIZE_W-1:0] BLOCK_WIDTH_RST  = 9'd8;
	localparam logic [BSIZE_W-1:0] BLOCK_HEIGHT_RST = 9'd8;
	localparam logic [ISIZE_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
	localparam logic [ISIZE_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_WIDTH  = 2'd0,
		REG_BLOCK_HEIGHT = 2'd1,
		REG_IMAGE_WIDTH  = 2'd2,
		REG_IMAGE_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_WAIT = 4'b1000
	} state_t;

	typedef logic [LANES-1:0][CHAN_W-1:0] chan4_t;
	typedef logic [LANES-1:0][SUM_W-1:0]  sum4_t;
	typedef logic [LANES-1:0][DVD_W-1:0]  dvd4_t;

endpackage

// ----- rtl/bap_ram.sv -----
module bap_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/bap_divider.sv -----
module bap_divider #(
	parameter int DIV_W = 18
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  bap_pkg::dvd4_t           dividend,
	input  logic [DIV_W-1:0]         divisor,
	output logic                     done,
	output bap_pkg::chan4_t          quotient
);
	import bap_pkg::*;

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic                           busy_q;
	logic                           done_q;
	logic [STEP_W-1:0]              step_q;
	logic [DIV_W-1:0]               divisor_q;
	dvd4_t                          dvd_q;
	logic [LANES-1:0][DIV_W-1:0]    rem_q;
	dvd4_t                          dvd_d;
	logic [LANES-1:0][DIV_W-1:0]    rem_d;

	// one quotient bit per lane and cycle, restoring
	always_comb begin
		logic [DIV_W:0] trial;
		for (int i = 0; i < LANES; i++) begin
			trial = {rem_q[i], dvd_q[i][DVD_W-1]};
			if (trial >= {1'b0, divisor_q}) begin
				rem_d[i] = DIV_W'(trial - {1'b0, divisor_q});
				dvd_d[i] = {dvd_q[i][DVD_W-2:0], 1'b1};
			end else begin
				rem_d[i] = trial[DIV_W-1:0];
				dvd_d[i] = {dvd_q[i][DVD_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			quotient[i] = dvd_q[i][CHAN_W-1:0];
		end
	end
endmodule

// ----- rtl/block_average_pixelate.sv -----
// Channel  Direction  Signals                       Content
// s_       in         s_tvalid s_tready s_tdata     pixel item, s_tuser = command
// m_       out        m_tvalid m_tready m_tdata     averaged pixel, m_tlast = frame done
// cfg_     in         cfg_we cfg_index cfg_data     block and image size registers
//
// An item first reads the sum and average memories, then updates the sums and
// loads the output register. An item that closes a block then waits for the
// bit-serial divider, which works out the quotient bit by bit, and for the
// write of the average. A block width write holds the input while the block
// positions are recomputed from the columns. Reset clears positions and bank
// status; memories are not cleared and need no clearing pass. A full output
// register stalls the item in its update cycle until m_tready takes the
// waiting result.
module block_average_pixelate #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_BLOCK = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bap_pkg::PIX_W-1:0]        s_tdata,   // red, green, blue, alpha
	input  logic                             s_tuser,   // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bap_pkg::PIX_W-1:0]        m_tdata,   // red, green, blue, alpha
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [bap_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bap_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bap_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int IW_W   = $clog2(MAX_WIDTH + 1);
	localparam int BW_W   = $clog2(MAX_BLOCK + 1);
	localparam int SUB_W  = $clog2(MAX_BLOCK);
	localparam int AREA_W = 2 * BW_W;
	localparam int AVG_AW = $clog2(2 * MAX_WIDTH);
	localparam int RS_STEP_W = $clog2(COL_W + 1);

	// configuration registers
	logic [BSIZE_W-1:0] bw_q, bh_q;
	logic [ISIZE_W-1:0] iw_q, ih_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= BLOCK_WIDTH_RST;
			bh_q <= BLOCK_HEIGHT_RST;
			iw_q <= IMAGE_WIDTH_RST;
			ih_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BLOCK_WIDTH:  bw_q <= cfg_data[BSIZE_W-1:0];
				REG_BLOCK_HEIGHT: bh_q <= cfg_data[BSIZE_W-1:0];
				REG_IMAGE_WIDTH:  iw_q <= cfg_data[ISIZE_W-1:0];
				REG_IMAGE_HEIGHT: ih_q <= cfg_data[ISIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp sizes: zero counts as one, oversize counts as the maximum
	logic [BW_W-1:0]   bw, bh;
	logic [IW_W-1:0]   iw, ih;
	logic [AREA_W-1:0] area;

	always_comb begin
		bw = (bw_q == '0) ? BW_W'(1) :
			((32'(bw_q) > MAX_BLOCK) ? BW_W'(MAX_BLOCK) : BW_W'(bw_q));
		bh = (bh_q == '0) ? BW_W'(1) :
			((32'(bh_q) > MAX_BLOCK) ? BW_W'(MAX_BLOCK) : BW_W'(bh_q));
		iw = (iw_q == '0) ? IW_W'(1) :
			((32'(iw_q) > MAX_WIDTH) ? IW_W'(MAX_WIDTH) : IW_W'(iw_q));
		ih = (ih_q == '0) ? IW_W'(1) :
			((32'(ih_q) > MAX_WIDTH) ? IW_W'(MAX_WIDTH) : IW_W'(ih_q));
		area = AREA_W'(bw) * AREA_W'(bh);
	end

	state_t state_q;

	// write-side position: column, block column and offset inside it, image row and row in band
	logic [COL_W-1:0] col_q, cblk_q, irow_q;
	logic [SUB_W-1:0] csub_q, rowb_q;
	// read-side position
	logic [COL_W-1:0] rcol_q, rblk_q;
	logic [SUB_W-1:0] rsub_q, rrow_q;
	logic             rbank_q, wbank_q;
	logic [1:0]       full_q, last_q;
	logic [1:0][BW_W-1:0] rows_q;

	// item latched at accept, bank and block latched at divider start
	chan4_t           item_s1;
	logic             cmd_s1, emit_s1, emit_last_s1;
	logic             wbank_s1;
	logic [COL_W-1:0] wblk_s1;

	// output register
	logic             out_valid_q, out_last_q;
	logic [PIX_W-1:0] out_data_q;

	// memories
	sum4_t             sums_rdata, sums_wdata;
	logic              sums_we;
	logic [PIX_W-1:0]  avg_rdata, avg_wdata;
	logic              avg_we;
	logic [AVG_AW-1:0] avg_raddr, avg_waddr;
	logic              accept;

	logic              div_start, div_done;
	dvd4_t             div_dividend;
	chan4_t            div_quot;

	// block position recompute after a block width write: column / width
	logic                 bw_wr;
	logic [RS_STEP_W-1:0] rs_step_q;
	logic [COL_W-1:0]     rs_cq_q, rs_rq_q, rs_cq_d, rs_rq_d;
	logic [BW_W-1:0]      rs_crem_q, rs_rrem_q, rs_crem_d, rs_rrem_d;
	logic [BW_W:0]        rs_ctrial, rs_rtrial;

	always_comb begin
		bw_wr     = cfg_we && (cfg_reg_t'(cfg_index) == REG_BLOCK_WIDTH);
		rs_ctrial = {rs_crem_q, rs_cq_q[COL_W-1]};
		rs_rtrial = {rs_rrem_q, rs_rq_q[COL_W-1]};
		if (rs_ctrial >= {1'b0, bw}) begin
			rs_crem_d = BW_W'(rs_ctrial - {1'b0, bw});
			rs_cq_d   = {rs_cq_q[COL_W-2:0], 1'b1};
		end else begin
			rs_crem_d = rs_ctrial[BW_W-1:0];
			rs_cq_d   = {rs_cq_q[COL_W-2:0], 1'b0};
		end
		if (rs_rtrial >= {1'b0, bw}) begin
			rs_rrem_d = BW_W'(rs_rtrial - {1'b0, bw});
			rs_rq_d   = {rs_rq_q[COL_W-2:0], 1'b1};
		end else begin
			rs_rrem_d = rs_rtrial[BW_W-1:0];
			rs_rq_d   = {rs_rq_q[COL_W-2:0], 1'b0};
		end
	end

	// readout decisions from the state before this item
	logic rb_sel, rd_have, row_end, band_end, rblk_end;

	always_comb begin
		rb_sel   = (!full_q[rbank_q] && full_q[!rbank_q]) ? !rbank_q : rbank_q;
		rd_have  = full_q[rb_sel];
		row_end  = (IW_W'(rcol_q) + IW_W'(1)) >= iw;
		band_end = row_end && ((BW_W'(rrow_q) + BW_W'(1)) >= rows_q[rb_sel]);
		rblk_end = (BW_W'(rsub_q) + BW_W'(1)) >= bw;
	end

	// hold the input while a block width write is taken
	assign s_tready  = (state_q == ST_IDLE) && !bw_wr;
	assign accept    = s_tvalid && s_tready;
	assign avg_raddr = AVG_AW'(rb_sel ? MAX_WIDTH : 0) + AVG_AW'(rblk_q);
	assign avg_waddr = AVG_AW'(wbank_s1 ? MAX_WIDTH : 0) + AVG_AW'(wblk_s1);

	// update step of the write side
	logic go, pix_upd, first, last_col, last_row_img, last_row_band, cblk_end, complete;

	always_comb begin
		go            = (state_q == ST_READ) && (!emit_s1 || !out_valid_q || m_tready);
		pix_upd       = go && (cmd_s1 == CMD_PIXEL);
		first         = (rowb_q == '0) && (csub_q == '0);
		last_col      = (IW_W'(col_q) + IW_W'(1)) >= iw;
		last_row_img  = (IW_W'(irow_q) + IW_W'(1)) >= ih;
		last_row_band = last_row_img || ((BW_W'(rowb_q) + BW_W'(1)) >= bh);
		cblk_end      = (BW_W'(csub_q) + BW_W'(1)) >= bw;
		complete      = last_row_band && (last_col || cblk_end);
		for (int i = 0; i < LANES; i++) begin
			sums_wdata[i]   = first ? SUM_W'(item_s1[i]) : sums_rdata[i] + SUM_W'(item_s1[i]);
			div_dividend[i] = DVD_W'(sums_wdata[i]) + DVD_W'(area >> 1);
		end
		sums_we   = pix_upd;
		div_start = pix_upd && complete;
		avg_we    = (state_q == ST_DIV) && div_done;
		avg_wdata = div_quot;
	end

	bap_ram #(.WIDTH(SUM_W * LANES), .DEPTH(MAX_WIDTH)) u_sums (
		.clk   (clk),
		.we    (sums_we),
		.waddr (cblk_q),
		.wdata (sums_wdata),
		.re    (accept),
		.raddr (cblk_q),
		.rdata (sums_rdata)
	);

	bap_ram #(.WIDTH(PIX_W), .DEPTH(2 * MAX_WIDTH)) u_avg (
		.clk   (clk),
		.we    (avg_we),
		.waddr (avg_waddr),
		.wdata (avg_wdata),
		.re    (accept),
		.raddr (avg_raddr),
		.rdata (avg_rdata)
	);

	bap_divider #(.DIV_W(AREA_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (area),
		.done     (div_done),
		.quotient (div_quot)
	);

	// control and positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			cblk_q      <= '0;
			csub_q      <= '0;
			rowb_q      <= '0;
			irow_q      <= '0;
			rcol_q      <= '0;
			rblk_q      <= '0;
			rsub_q      <= '0;
			rrow_q      <= '0;
			rbank_q     <= 1'b0;
			wbank_q     <= 1'b0;
			full_q      <= '0;
			last_q      <= '0;
			rows_q      <= '0;
			out_valid_q <= 1'b0;
			rs_step_q   <= '0;
		end else begin
			// load a new output item, else drop the current one once taken
			if (go && emit_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
						rbank_q <= (rd_have && band_end) ? !rb_sel : rb_sel;
						if (rd_have) begin
							if (band_end) begin
								full_q[rb_sel] <= 1'b0;
								rcol_q         <= '0;
								rblk_q         <= '0;
								rsub_q         <= '0;
								rrow_q         <= '0;
							end else if (row_end) begin
								rcol_q <= '0;
								rblk_q <= '0;
								rsub_q <= '0;
								rrow_q <= rrow_q + 1'b1;
							end else begin
								rcol_q <= rcol_q + 1'b1;
								if (rblk_end) begin
									rsub_q <= '0;
									rblk_q <= rblk_q + 1'b1;
								end else begin
									rsub_q <= rsub_q + 1'b1;
								end
							end
						end
					end else if (bw_wr) begin
						state_q   <= ST_WAIT;
						rs_step_q <= RS_STEP_W'(COL_W);
					end
				end
				ST_READ: begin
					if (go) begin
						state_q <= (pix_upd && complete) ? ST_DIV : ST_IDLE;
						if (pix_upd) begin
							if (last_col) begin
								col_q  <= '0;
								cblk_q <= '0;
								csub_q <= '0;
								if (last_row_band) begin
									full_q[wbank_q] <= 1'b1;
									rows_q[wbank_q] <= BW_W'(rowb_q) + BW_W'(1);
									last_q[wbank_q] <= last_row_img;
									wbank_q         <= !wbank_q;
									rowb_q          <= '0;
								end else begin
									rowb_q <= rowb_q + 1'b1;
								end
								irow_q <= last_row_img ? '0 : irow_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
								if (cblk_end) begin
									csub_q <= '0;
									cblk_q <= cblk_q + 1'b1;
								end else begin
									csub_q <= csub_q + 1'b1;
								end
							end
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WAIT: begin
					// restart on another width write, else advance one quotient bit
					if (bw_wr) begin
						rs_step_q <= RS_STEP_W'(COL_W);
					end else begin
						rs_step_q <= rs_step_q - 1'b1;
						if (rs_step_q == RS_STEP_W'(1)) begin
							state_q <= ST_IDLE;
							cblk_q  <= rs_cq_d;
							csub_q  <= SUB_W'(rs_crem_d);
							rblk_q  <= rs_rq_d;
							rsub_q  <= SUB_W'(rs_rrem_d);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1      <= s_tdata;
			cmd_s1       <= s_tuser;
			emit_s1      <= rd_have;
			emit_last_s1 <= band_end && last_q[rb_sel];
		end
		if (go && emit_s1) begin
			out_data_q <= avg_rdata;
			out_last_q <= emit_last_s1;
		end
		if (div_start) begin
			wbank_s1 <= wbank_q;
			wblk_s1  <= cblk_q;
		end
		if (bw_wr) begin
			rs_cq_q   <= col_q;
			rs_rq_q   <= rcol_q;
			rs_crem_q <= '0;
			rs_rrem_q <= '0;
		end else if (state_q == ST_WAIT) begin
			rs_cq_q   <= rs_cq_d;
			rs_rq_q   <= rs_rq_d;
			rs_crem_q <= rs_crem_d;
			rs_rrem_q <= rs_rrem_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
endmodule

// ----- rtl/bap_checker.sv -----
module bap_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [bap_pkg::PIX_W-1:0]        m_tdata,
	input logic                             m_tlast
);
	// a stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// one item at a time: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// a new output item is loaded only while the input side is busy
	a_out_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("output item appeared without an item in work");
endmodule

bind block_average_pixelate bap_checker u_bap_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
